>>> src/hkrt_pkg.sv
// ----------------------------------------------------------------------------
// hkrt_pkg: shared types and constants for the hall key rapid trigger
// Holds field widths, register indexes, mode and event codes, the state
// machine encoding and the structs that pass between the block's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hkrt_pkg;

	// Fixed field widths.
	localparam int SAMPLE_W = 12;
	localparam int HYST_W   = 9;
	localparam int OUT_W    = 9;
	localparam int IDX_W    = 3;
	localparam int CFG_W    = 12;

	// Defaults for the top level parameters.
	localparam int TRAVEL_MAX_DEF = 400;
	localparam int CRT_MARGIN_DEF = 10;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_MODE      = 3'd0;
	localparam logic [IDX_W-1:0] REG_LOWER     = 3'd1;
	localparam logic [IDX_W-1:0] REG_UPPER     = 3'd2;
	localparam logic [IDX_W-1:0] REG_DOWN_SENS = 3'd3;
	localparam logic [IDX_W-1:0] REG_UP_SENS   = 3'd4;
	localparam logic [IDX_W-1:0] REG_HID_EN    = 3'd5;
	localparam logic [IDX_W-1:0] REG_DOWN_POS  = 3'd6;
	localparam logic [IDX_W-1:0] REG_REST_POS  = 3'd7;

	// Actuation mode codes; the spare code behaves like continuous mode.
	localparam logic [1:0] MODE_TRADITIONAL = 2'd0;
	localparam logic [1:0] MODE_RAPID       = 2'd1;
	localparam logic [1:0] MODE_CONTINUOUS  = 2'd2;
	localparam logic [1:0] MODE_SPARE       = 2'd3;

	// Key event codes.
	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_PRESS   = 2'd1,
		EV_RELEASE = 2'd2
	} key_event_t;

	// Sequencer states of the top level.
	typedef enum logic [1:0] {
		S_IDLE,
		S_PREP,
		S_DIV
	} state_t;

	// Settings the trigger logic needs.
	typedef struct packed {
		logic [1:0]        mode;
		logic [HYST_W-1:0] lower;
		logic [HYST_W-1:0] upper;
		logic [HYST_W-1:0] down_sens;
		logic [HYST_W-1:0] up_sens;
		logic              hid_enable;
	} trig_cfg_t;

	// Key state reported after one item.
	typedef struct packed {
		logic       key_down;
		key_event_t key_event;
		logic       zone;
	} trig_res_t;

endpackage

`default_nettype wire

>>> src/hkrt_divider.sv
// ----------------------------------------------------------------------------
// hkrt_divider: bit-serial restoring divider
// Shifts the dividend out one bit per cycle against a narrow remainder and
// shifts the quotient in at the bottom.
// ----------------------------------------------------------------------------
`default_nettype none

module hkrt_divider
	import hkrt_pkg::*;
#(
	parameter int NUM_W = 21,
	parameter int DEN_W = SAMPLE_W
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] dividend,
	input  wire logic [DEN_W-1:0] divisor,
	output logic      [NUM_W-1:0] quotient,
	output logic                  done
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] work_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   trial;
	logic             fits;
	logic [DEN_W-1:0] rem_next;

	// One restoring step: bring in the next dividend bit and try to subtract.
	always_comb begin
		trial    = {rem_q, work_q[NUM_W-1]};
		fits     = (trial >= {1'b0, div_q});
		rem_next = fits ? DEN_W'(trial - {1'b0, div_q}) : trial[DEN_W-1:0];
	end

	// Step counter and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(NUM_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Dividend and remainder shift registers, and the held divisor.
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			div_q  <= divisor;
		end else if (busy_q) begin
			work_q <= {work_q[NUM_W-2:0], fits};
			rem_q  <= rem_next;
		end
	end

	assign quotient = work_q;
	assign done     = done_q;

endmodule

`default_nettype wire

>>> src/hkrt_trigger.sv
// ----------------------------------------------------------------------------
// hkrt_trigger: press, release and zone decisions for one key
// Holds the pressed flag, the zone flag and the tracked peak, and updates
// them from one mapped travel distance per update pulse.
// ----------------------------------------------------------------------------
`default_nettype none

module hkrt_trigger
	import hkrt_pkg::*;
#(
	parameter int TRAVEL_MAX         = TRAVEL_MAX_DEF,
	parameter int CRT_RELEASE_MARGIN = CRT_MARGIN_DEF,
	parameter int DIST_W             = $clog2(TRAVEL_MAX_DEF + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              update,
	input  wire logic [DIST_W-1:0] travel,
	input  wire trig_cfg_t         cfg,
	output trig_res_t              res
);

	// Comparisons run one bit wider than the widest operand.
	localparam int CMP_W = ((DIST_W > HYST_W) ? DIST_W : HYST_W) + 1;
	localparam logic [CMP_W-1:0] LEAVE_LVL = CMP_W'(TRAVEL_MAX - CRT_RELEASE_MARGIN);

	logic              pressed_q;
	logic              zone_q;
	logic [DIST_W-1:0] peak_q;

	logic              pressed_d;
	logic              zone_d;
	logic [DIST_W-1:0] peak_d;
	logic [CMP_W-1:0]  v;
	logic [CMP_W-1:0]  peak;
	logic [CMP_W-1:0]  lower;
	logic [CMP_W-1:0]  upper;
	logic              rapid;
	logic              cont;

	// Next key state from the new distance.
	always_comb begin
		v         = CMP_W'(travel);
		peak      = CMP_W'(peak_q);
		lower     = CMP_W'(cfg.lower);
		upper     = CMP_W'(cfg.upper);
		rapid     = (cfg.mode != MODE_TRADITIONAL);
		cont      = cfg.mode inside {MODE_CONTINUOUS, MODE_SPARE};
		pressed_d = pressed_q;
		zone_d    = zone_q;
		peak_d    = peak_q;

		if (!rapid) begin
			if (v <= lower) begin
				pressed_d = pressed_q | cfg.hid_enable;
			end else if (v >= upper) begin
				pressed_d = 1'b0;
			end
		end else begin
			// Leave the zone near the top of travel.
			if (!cont && v >= upper) begin
				zone_d = 1'b0;
			end else if (cont && v >= LEAVE_LVL) begin
				zone_d = 1'b0;
			end

			// Enter the zone, or trigger relative to the peak.
			if (v <= lower && !zone_d) begin
				pressed_d = pressed_q | cfg.hid_enable;
				zone_d    = 1'b1;
			end else if (!pressed_q && zone_d &&
					(v + CMP_W'(cfg.down_sens) <= peak)) begin
				pressed_d = cfg.hid_enable;
			end else if (pressed_q &&
					(!zone_d || v >= peak + CMP_W'(cfg.up_sens))) begin
				pressed_d = 1'b0;
			end

			// Follow the peak in the current direction of travel.
			if ((pressed_d && v < peak) || (!pressed_d && v > peak)) begin
				peak_d = travel;
			end
		end

		res.key_down = pressed_d;
		res.zone     = zone_d;
		if (!pressed_q && pressed_d) begin
			res.key_event = EV_PRESS;
		end else if (pressed_q && !pressed_d) begin
			res.key_event = EV_RELEASE;
		end else begin
			res.key_event = EV_NONE;
		end
	end

	// Key state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q <= 1'b0;
			zone_q    <= 1'b0;
			peak_q    <= '0;
		end else if (update) begin
			pressed_q <= pressed_d;
			zone_q    <= zone_d;
			peak_q    <= peak_d;
		end
	end

endmodule

`default_nettype wire

>>> src/hall_key_rapid_trigger.sv
// ----------------------------------------------------------------------------
// hall_key_rapid_trigger: rapid trigger actuation for one analog hall key
// Flow: a sample is taken only when idle; it is registered, the divider runs
// on a NUM_W-bit dividend (21 bits at TRAVEL_MAX = 400), and the result item
// is loaded once the output register is free or read, before the next sample
// is taken. The bit-serial divider resolves one quotient bit per cycle.
// Reset: arst_n clears the key state and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module hall_key_rapid_trigger
	import hkrt_pkg::*;
#(
	parameter int TRAVEL_MAX         = TRAVEL_MAX_DEF,
	parameter int CRT_RELEASE_MARGIN = CRT_MARGIN_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_W-1:0]    cfg_data,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [SAMPLE_W-1:0] raw_sample,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic                     key_down,
	output logic [1:0]               key_event,
	output logic                     zone_flag,
	output logic [OUT_W-1:0]         travel_distance
);

	localparam int DIST_W = $clog2(TRAVEL_MAX + 1);
	localparam int NUM_W  = $clog2((2 ** SAMPLE_W - 1) * TRAVEL_MAX + 1);
	localparam int EXT_W  = ((DIST_W > OUT_W) ? DIST_W : OUT_W);
	localparam logic [NUM_W-1:0]  MAX_NUM  = NUM_W'(TRAVEL_MAX);
	localparam logic [DIST_W-1:0] MAX_DIST = DIST_W'(TRAVEL_MAX);

	// Configuration registers.
	logic [1:0]          mode_q;
	logic [HYST_W-1:0]   lower_q;
	logic [HYST_W-1:0]   upper_q;
	logic [HYST_W-1:0]   down_sens_q;
	logic [HYST_W-1:0]   up_sens_q;
	logic                hid_en_q;
	logic [SAMPLE_W-1:0] down_pos_q;
	logic [SAMPLE_W-1:0] rest_pos_q;

	state_t              state_q;
	state_t              state_d;
	logic [SAMPLE_W-1:0] raw_q;
	logic                zero_q;
	logic                out_valid_q;
	trig_res_t           out_res_q;
	logic [DIST_W-1:0]   out_dist_q;

	logic                in_fire;
	logic                div_start;
	logic                load_out;
	logic [SAMPLE_W:0]   diff;
	logic [SAMPLE_W:0]   span;
	logic [SAMPLE_W-1:0] diff_mag;
	logic [SAMPLE_W-1:0] span_mag;
	logic                zero_res;
	logic [NUM_W-1:0]    num;
	logic [NUM_W-1:0]    quot;
	logic                div_done;
	logic [DIST_W-1:0]   travel;
	logic [EXT_W-1:0]    dist_ext;
	trig_cfg_t           trig_cfg;
	trig_res_t           trig_res;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_TRADITIONAL;
			lower_q     <= HYST_W'(290);
			upper_q     <= HYST_W'(310);
			down_sens_q <= HYST_W'(10);
			up_sens_q   <= HYST_W'(10);
			hid_en_q    <= 1'b1;
			down_pos_q  <= '0;
			rest_pos_q  <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:      mode_q      <= cfg_data[1:0];
				REG_LOWER:     lower_q     <= cfg_data[HYST_W-1:0];
				REG_UPPER:     upper_q     <= cfg_data[HYST_W-1:0];
				REG_DOWN_SENS: down_sens_q <= cfg_data[HYST_W-1:0];
				REG_UP_SENS:   up_sens_q   <= cfg_data[HYST_W-1:0];
				REG_HID_EN:    hid_en_q    <= cfg_data[0];
				REG_DOWN_POS:  down_pos_q  <= cfg_data[SAMPLE_W-1:0];
				REG_REST_POS:  rest_pos_q  <= cfg_data[SAMPLE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Signed offsets of the sample and of the rest position from the bottom.
	// The quotient is used only when both share a sign; otherwise the clamped
	// result is zero, as it is for equal calibration points.
	always_comb begin
		diff     = {1'b0, raw_q} - {1'b0, down_pos_q};
		span     = {1'b0, rest_pos_q} - {1'b0, down_pos_q};
		diff_mag = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
		span_mag = span[SAMPLE_W] ? SAMPLE_W'(-span) : span[SAMPLE_W-1:0];
		zero_res = (span == '0) || (diff == '0) || (diff[SAMPLE_W] != span[SAMPLE_W]);
		num      = NUM_W'(NUM_W'(diff_mag) * MAX_NUM);
	end

	hkrt_divider #(
		.NUM_W(NUM_W),
		.DEN_W(SAMPLE_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(num),
		.divisor (span_mag),
		.quotient(quot),
		.done    (div_done)
	);

	// Clamp the quotient to the travel range.
	always_comb begin
		if (zero_q) begin
			travel = '0;
		end else if (quot > MAX_NUM) begin
			travel = MAX_DIST;
		end else begin
			travel = quot[DIST_W-1:0];
		end
	end

	assign trig_cfg = '{
		mode:       mode_q,
		lower:      lower_q,
		upper:      upper_q,
		down_sens:  down_sens_q,
		up_sens:    up_sens_q,
		hid_enable: hid_en_q
	};

	hkrt_trigger #(
		.TRAVEL_MAX        (TRAVEL_MAX),
		.CRT_RELEASE_MARGIN(CRT_RELEASE_MARGIN),
		.DIST_W            (DIST_W)
	) u_trig (
		.clk   (clk),
		.arst_n(arst_n),
		.update(load_out),
		.travel(travel),
		.cfg   (trig_cfg),
		.res   (trig_res)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and controls.
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				div_start = 1'b1;
				state_d   = S_DIV;
			end
			S_DIV: begin
				if (div_done && (!out_valid_q || out_ready)) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_fire = in_valid && in_ready;

	// Sample capture and the zero-result flag.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			raw_q <= raw_sample;
		end
		if (div_start) begin
			zero_q <= zero_res;
		end
	end

	// Output item register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_res_q  <= trig_res;
			out_dist_q <= travel;
		end
	end

	assign dist_ext        = EXT_W'(out_dist_q);
	assign out_valid       = out_valid_q;
	assign key_down        = out_res_q.key_down;
	assign key_event       = out_res_q.key_event;
	assign zone_flag       = out_res_q.zone;
	assign travel_distance = dist_ext[OUT_W-1:0];

endmodule

`default_nettype wire

>>> verif/tb_hall_key_rapid_trigger.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hall_key_rapid_trigger: self-checking bench for the hall key actuation
// A short table of directed samples and register writes runs first, then
// random key strokes under random settings. Every result item is compared with
// a typed value or a cycle-free model of the travel map and three trigger modes.
// ----------------------------------------------------------------------------

module tb_hall_key_rapid_trigger;
	import hkrt_pkg::*;

	localparam int TRAVEL_MAX = TRAVEL_MAX_DEF;
	localparam int CRT_MARGIN = CRT_MARGIN_DEF;
	localparam int END_PAUSE  = 40;
	localparam int TIMEOUT_NS = 5_000_000;

	// Expected key state of one result item.
	typedef struct packed {
		logic              key_down;
		key_event_t        key_event;
		logic              zone;
		logic [OUT_W-1:0]  travel;
	} key_report_t;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	// One line of the directed table.
	typedef struct {
		row_kind_t         kind;
		logic [IDX_W-1:0]  index;
		logic [CFG_W-1:0]  value;
		bit                typed;
		key_report_t       want;
	} stim_row_t;

	localparam key_report_t NO_REPORT = key_report_t'{1'b0, EV_NONE, 1'b0, 9'd0};

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [IDX_W-1:0]    cfg_index;
	logic [CFG_W-1:0]    cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic [SAMPLE_W-1:0] raw_sample;
	logic                out_valid;
	logic                out_ready;
	logic                key_down;
	logic [1:0]          key_event;
	logic                zone_flag;
	logic [OUT_W-1:0]    travel_distance;

	// Model copy of the registers.
	logic [1:0]          set_mode;
	logic [HYST_W-1:0]   set_lower;
	logic [HYST_W-1:0]   set_upper;
	logic [HYST_W-1:0]   set_down_sens;
	logic [HYST_W-1:0]   set_up_sens;
	logic                set_hid;
	logic [SAMPLE_W-1:0] set_down_pos;
	logic [SAMPLE_W-1:0] set_rest_pos;

	// Model copy of the key state.
	bit                  key_pressed;
	bit                  key_in_zone;
	int                  key_peak;

	key_report_t         pending_reports[$];
	stim_row_t           directed_rows[$];
	int                  mismatch_count;
	int                  send_idle_pct;
	int                  recv_idle_pct;

	hall_key_rapid_trigger dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.raw_sample      (raw_sample),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.key_down        (key_down),
		.key_event       (key_event),
		.zone_flag       (zone_flag),
		.travel_distance (travel_distance)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Linear map from the calibrated span onto 0..TRAVEL_MAX, clamped.
	function automatic int travel_of(logic [SAMPLE_W-1:0] raw);
		int lo;
		int hi;
		int d;
		lo = int'(set_down_pos);
		hi = int'(set_rest_pos);
		if (lo == hi)
			return 0;
		d = ((int'(raw) - lo) * TRAVEL_MAX) / (hi - lo);
		if (d < 0)
			d = 0;
		if (d > TRAVEL_MAX)
			d = TRAVEL_MAX;
		return d;
	endfunction

	// Advance the key state by one sample and return the report it gives.
	function automatic key_report_t predict_key(logic [SAMPLE_W-1:0] raw);
		key_report_t rep;
		int          v;
		bit          was;
		bit          rapid;
		bit          cont;
		v     = travel_of(raw);
		was   = key_pressed;
		rapid = (set_mode != MODE_TRADITIONAL);
		cont  = set_mode[1];
		if (!rapid) begin
			if (v <= int'(set_lower)) begin
				if (set_hid)
					key_pressed = 1'b1;
			end else if (v >= int'(set_upper)) begin
				key_pressed = 1'b0;
			end
		end else begin
			// Leaving the zone comes first.
			if (!cont && v >= int'(set_upper))
				key_in_zone = 1'b0;
			else if (cont && v >= TRAVEL_MAX - CRT_MARGIN)
				key_in_zone = 1'b0;
			// Zone entry, or a press or release relative to the peak.
			if (v <= int'(set_lower) && !key_in_zone) begin
				if (set_hid)
					key_pressed = 1'b1;
				key_in_zone = 1'b1;
			end else if (!key_pressed && key_in_zone &&
					v + int'(set_down_sens) <= key_peak) begin
				if (set_hid)
					key_pressed = 1'b1;
			end else if (key_pressed &&
					(!key_in_zone || v >= key_peak + int'(set_up_sens))) begin
				key_pressed = 1'b0;
			end
			// The peak follows the key in its current direction.
			if ((key_pressed && v < key_peak) || (!key_pressed && v > key_peak))
				key_peak = v;
		end
		rep.key_down  = key_pressed;
		rep.key_event = (!was && key_pressed) ? EV_PRESS :
				(was && !key_pressed) ? EV_RELEASE : EV_NONE;
		rep.zone      = key_in_zone;
		rep.travel    = v[OUT_W-1:0];
		return rep;
	endfunction

	task automatic note_mismatch(string field, int want, int got);
		mismatch_count++;
		$display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
	endtask

	// Result side: random stalls, and every item checked against the oldest
	// expectation.
	always @(posedge clk) begin
		key_report_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_reports.size() == 0) begin
					note_mismatch("unexpected result item, travel", -1,
						int'(travel_distance));
				end else begin
					want = pending_reports.pop_front();
					if (want.key_down !== key_down)
						note_mismatch("key_down", want.key_down, key_down);
					if (want.key_event !== key_event)
						note_mismatch("key_event", want.key_event, key_event);
					if (want.zone !== zone_flag)
						note_mismatch("zone_flag", want.zone, zone_flag);
					if (want.travel !== travel_distance)
						note_mismatch("travel_distance", want.travel, travel_distance);
				end
			end
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Drop valid and let every outstanding result come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
	endtask

	// One register write; the enable is lowered by whoever drives next.
	task automatic write_reg(logic [IDX_W-1:0] index, logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		case (index)
			REG_MODE:      set_mode      = value[1:0];
			REG_LOWER:     set_lower     = value[HYST_W-1:0];
			REG_UPPER:     set_upper     = value[HYST_W-1:0];
			REG_DOWN_SENS: set_down_sens = value[HYST_W-1:0];
			REG_UP_SENS:   set_up_sens   = value[HYST_W-1:0];
			REG_HID_EN:    set_hid       = value[0];
			REG_DOWN_POS:  set_down_pos  = value;
			REG_REST_POS:  set_rest_pos  = value;
			default: ;
		endcase
	endtask

	// Offer one sample item and record what it should produce.
	task automatic send_sample(logic [SAMPLE_W-1:0] raw, bit typed, key_report_t typed_want);
		key_report_t want;
		cfg_we <= 1'b0;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		raw_sample <= raw;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		want = predict_key(raw);
		pending_reports.push_back(typed ? typed_want : want);
	endtask

	task automatic add_sample_row(logic [SAMPLE_W-1:0] raw, bit typed, key_report_t want);
		stim_row_t r;
		r.kind  = ROW_SAMPLE;
		r.index = REG_MODE;
		r.value = raw;
		r.typed = typed;
		r.want  = want;
		directed_rows.push_back(r);
	endtask

	task automatic add_write_row(logic [IDX_W-1:0] index, logic [CFG_W-1:0] value);
		stim_row_t r;
		r.kind  = ROW_WRITE;
		r.index = index;
		r.value = value;
		r.typed = 1'b0;
		r.want  = NO_REPORT;
		directed_rows.push_back(r);
	endtask

	// Sometimes set bits above the register width; they must be dropped.
	function automatic logic [CFG_W-1:0] with_junk(int value, int width);
		logic [CFG_W-1:0] junk;
		junk = $urandom_range(0, 4095);
		if ($urandom_range(0, 3) == 0)
			return CFG_W'(value) | (junk & ~((CFG_W'(1) << width) - 1'b1));
		return CFG_W'(value);
	endfunction

	function automatic int pick_threshold();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 400;
			2: return 511;
			default: return $urandom_range(0, 400);
		endcase
	endfunction

	function automatic int pick_sensitivity();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 400;
			2: return 511;
			default: return $urandom_range(1, 40);
		endcase
	endfunction

	// Fresh random settings, written once the block has gone idle.
	task automatic load_random_settings();
		int lower;
		int upper;
		int sel;
		int down_pos;
		int rest_pos;
		lower = pick_threshold();
		upper = ($urandom_range(0, 9) < 6) ? lower + $urandom_range(0, 60) : pick_threshold();
		if (upper > 511)
			upper = 511;
		sel = $urandom_range(0, 99);
		if (sel < 60) begin
			down_pos = $urandom_range(0, 1500);
			rest_pos = $urandom_range(2500, 4095);
		end else if (sel < 72) begin
			down_pos = 0;
			rest_pos = 4095;
		end else if (sel < 82) begin
			down_pos = $urandom_range(0, 4095);
			rest_pos = down_pos;
		end else begin
			down_pos = $urandom_range(2500, 4095);
			rest_pos = $urandom_range(0, 1500);
		end
		wait_drained();
		write_reg(REG_MODE, with_junk($urandom_range(0, 3), 2));
		write_reg(REG_LOWER, with_junk(lower, HYST_W));
		write_reg(REG_UPPER, with_junk(upper, HYST_W));
		write_reg(REG_DOWN_SENS, with_junk(pick_sensitivity(), HYST_W));
		write_reg(REG_UP_SENS, with_junk(pick_sensitivity(), HYST_W));
		write_reg(REG_HID_EN, with_junk(($urandom_range(0, 99) < 85) ? 1 : 0, 1));
		write_reg(REG_DOWN_POS, CFG_W'(down_pos));
		write_reg(REG_REST_POS, CFG_W'(rest_pos));
	endtask

	// Key strokes between random depths of the calibrated span, with some
	// fully random samples mixed in as noise.
	task automatic drive_strokes(int n_items, int hold_at);
		int                  lo_r;
		int                  hi_r;
		int                  pos;
		int                  goal;
		int                  stride;
		logic [SAMPLE_W-1:0] raw;
		lo_r = (set_down_pos < set_rest_pos) ? int'(set_down_pos) : int'(set_rest_pos);
		hi_r = (set_down_pos < set_rest_pos) ? int'(set_rest_pos) : int'(set_down_pos);
		pos  = hi_r;
		goal = hi_r;
		for (int i = 0; i < n_items; i++) begin
			if (i == hold_at)
				wait_drained();
			if ($urandom_range(0, 99) < 15) begin
				raw = $urandom_range(0, 4095);
			end else begin
				if (pos == goal) begin
					case ($urandom_range(0, 3))
						0: goal = lo_r;
						1: goal = hi_r;
						default: goal = $urandom_range(lo_r, hi_r);
					endcase
				end
				stride = $urandom_range(1, (hi_r - lo_r) / 6 + 1);
				if (pos < goal)
					pos = (pos + stride > goal) ? goal : pos + stride;
				else
					pos = (pos - stride < goal) ? goal : pos - stride;
				raw = pos[SAMPLE_W-1:0];
			end
			send_sample(raw, 1'b0, NO_REPORT);
		end
	endtask

	// Run limit.
	initial begin
		#(TIMEOUT_NS);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Stimulus and the end of the run.
	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_MODE;
		cfg_data      = '0;
		in_valid      = 1'b0;
		raw_sample    = '0;
		mismatch_count = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_mode      = MODE_TRADITIONAL;
		set_lower     = 9'd290;
		set_upper     = 9'd310;
		set_down_sens = 9'd10;
		set_up_sens   = 9'd10;
		set_hid       = 1'b1;
		set_down_pos  = 12'd0;
		set_rest_pos  = 12'd4095;
		key_pressed   = 1'b0;
		key_in_zone   = 1'b0;
		key_peak      = 0;

		// Traditional mode from the reset settings, fields at their extremes.
		add_sample_row(12'd0, 1'b1, key_report_t'{1'b1, EV_PRESS, 1'b0, 9'd0});
		add_sample_row(12'd4095, 1'b1, key_report_t'{1'b0, EV_RELEASE, 1'b0, 9'd400});
		add_sample_row(12'd2048, 1'b0, NO_REPORT);
		add_sample_row(12'hAAA, 1'b0, NO_REPORT);
		add_sample_row(12'h555, 1'b0, NO_REPORT);
		// Rapid trigger: zone entry, peak release, peak press, zone exit.
		add_write_row(REG_MODE, CFG_W'(MODE_RAPID));
		add_sample_row(12'd4095, 1'b0, NO_REPORT);
		add_sample_row(12'd3000, 1'b0, NO_REPORT);
		add_sample_row(12'd2900, 1'b0, NO_REPORT);
		add_sample_row(12'd2500, 1'b0, NO_REPORT);
		add_sample_row(12'd2700, 1'b0, NO_REPORT);
		add_sample_row(12'd2550, 1'b0, NO_REPORT);
		add_sample_row(12'd4095, 1'b0, NO_REPORT);
		// Continuous mode keeps the zone until nearly fully released.
		add_write_row(REG_MODE, CFG_W'(MODE_CONTINUOUS));
		add_sample_row(12'd2000, 1'b0, NO_REPORT);
		add_sample_row(12'd3500, 1'b0, NO_REPORT);
		add_sample_row(12'd4000, 1'b0, NO_REPORT);
		// The spare mode code acts as continuous mode.
		add_write_row(REG_MODE, CFG_W'(MODE_SPARE));
		add_sample_row(12'd1000, 1'b0, NO_REPORT);
		add_sample_row(12'd4095, 1'b0, NO_REPORT);
		// Press disabled: a full press gives nothing.
		add_write_row(REG_MODE, CFG_W'(MODE_TRADITIONAL));
		add_write_row(REG_HID_EN, 12'd0);
		add_sample_row(12'd0, 1'b1, key_report_t'{1'b0, EV_NONE, 1'b0, 9'd0});
		// Equal calibration maps every sample to zero distance.
		add_write_row(REG_DOWN_POS, 12'd2048);
		add_write_row(REG_REST_POS, 12'd2048);
		add_sample_row(12'd4095, 1'b1, key_report_t'{1'b0, EV_NONE, 1'b0, 9'd0});
		add_write_row(REG_HID_EN, 12'd1);
		add_sample_row(12'd1234, 1'b1, key_report_t'{1'b1, EV_PRESS, 1'b0, 9'd0});
		// Reversed calibration, clamped at both ends.
		add_write_row(REG_DOWN_POS, 12'd4095);
		add_write_row(REG_REST_POS, 12'd0);
		add_sample_row(12'd0, 1'b1, key_report_t'{1'b0, EV_RELEASE, 1'b0, 9'd400});
		add_sample_row(12'd4095, 1'b1, key_report_t'{1'b1, EV_PRESS, 1'b0, 9'd0});
		add_sample_row(12'd2000, 1'b0, NO_REPORT);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				wait_drained();
				write_reg(directed_rows[i].index, directed_rows[i].value);
			end else begin
				send_sample(directed_rows[i].value, directed_rows[i].typed,
					directed_rows[i].want);
			end
		end

		// Random part: sender-light stalls, receiver-light stalls, then none.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 71 : 0;
			recv_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 17 : 0;
			for (int k = 0; k < 4; k++) begin
				load_random_settings();
				drive_strokes(33, (ph == 1 && k == 2) ? 16 : -1);
			end
		end

		wait_drained();
		repeat (END_PAUSE) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
